### rtl/max_tournament_tree_macros.svh
// ----------------------------------------------------------------------------
// max_tournament_tree_macros
// assertion helpers shared by the tournament tree modules
// ----------------------------------------------------------------------------
`ifndef MAX_TOURNAMENT_TREE_MACROS_SVH
`define MAX_TOURNAMENT_TREE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// types, constants and the control program of the max tournament tree
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int LEAVES     = 32;
    localparam int DATA_W     = 16;
    localparam int VALUE_W    = 16;
    localparam int OCC_W      = 6;
    localparam int NODE_COUNT = 2 * LEAVES - 1;
    localparam int FIRST_LEAF = LEAVES - 1;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(LEAVES + 1);
    localparam int STEP_W     = 5;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic               error;
        logic [OCC_W-1:0]   occupancy;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
    } t_node;

    typedef struct packed {
        logic  rd_a_en;
        t_idx  rd_a_addr;
        logic  rd_b_en;
        t_idx  rd_b_addr;
        logic  wr_en;
        t_idx  wr_addr;
        t_node wr_data;
    } t_ram_req;

    typedef struct packed {
        t_node rd_a;
        t_node rd_b;
        logic  root_valid;
    } t_ram_rsp;

    typedef enum logic [STEP_W-1:0] {
        S_DISP_ERR, S_DISP_OP,
        S_I_LEAF, S_I_WRITE, S_I_UP, S_I_CMP, S_I_WUP,
        S_FIN, S_ERR,
        S_X_ROOT, S_X_KIDS, S_X_PICK, S_X_TEST, S_X_DOWN,
        S_X_LAST, S_X_RDL, S_X_MOVE, S_X_CLR,
        S_R_UP, S_R_KIDS, S_R_WR, S_R_AUX,
        S_S_UP, S_S_KIDS, S_S_WR, S_S_END
    } t_step;

    typedef enum logic [2:0] {
        NS_HOLD, NS_NEW_LEAF, NS_PARENT, NS_ZERO, NS_WINNER, NS_LAST, NS_AUX
    } t_node_sel;

    typedef enum logic [2:0] {
        RS_NONE, RS_PARENT, RS_ROOT, RS_KIDS, RS_NODE
    } t_rd_sel;

    typedef enum logic [2:0] {
        WS_NONE, WS_VAL_NODE, WS_RDA_AUX, WS_EMPTY_NODE, WS_WIN_NODE
    } t_wr_sel;

    typedef enum logic [1:0] {
        CO_HOLD, CO_INC, CO_DEC
    } t_cnt_op;

    typedef enum logic [2:0] {
        C_NEVER, C_ALWAYS, C_ERROR, C_OP_EXT, C_NOT_BEATS, C_NOT_ROOT, C_AT_LEAF
    } t_cond;

    typedef struct packed {
        t_node_sel node_sel;
        logic      aux_ld;
        t_rd_sel   rd_sel;
        t_wr_sel   wr_sel;
        t_cnt_op   cnt_op;
        logic      res_ld;
        t_cond     cond;
        t_step     target;
        logic      done;
        logic      err;
    } t_uword;

    typedef struct packed {
        logic err_cond;
        logic op_ext;
        logic not_beats;
        logic not_root;
        logic at_leaf;
    } t_status;

    typedef struct packed {
        t_uword uw;
        logic   accept;
        logic   fire;
    } t_ctl;

    localparam t_uword UW_NOP = '{
        node_sel: NS_HOLD, aux_ld: 1'b0, rd_sel: RS_NONE, wr_sel: WS_NONE,
        cnt_op: CO_HOLD, res_ld: 1'b0, cond: C_NEVER, target: S_DISP_ERR,
        done: 1'b0, err: 1'b0
    };

    // control program, one word per step
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = UW_NOP;
        case (s)
            S_DISP_ERR: begin w.cond = C_ERROR;  w.target = S_ERR; end
            S_DISP_OP:  begin w.cond = C_OP_EXT; w.target = S_X_ROOT; end
            // insert: place in next free leaf, climb while strictly larger
            S_I_LEAF:   w.node_sel = NS_NEW_LEAF;
            S_I_WRITE:  begin w.wr_sel = WS_VAL_NODE; w.cnt_op = CO_INC; end
            S_I_UP:     begin w.rd_sel = RS_PARENT; w.node_sel = NS_PARENT; end
            S_I_CMP:    begin w.cond = C_NOT_BEATS; w.target = S_FIN; end
            S_I_WUP: begin
                w.wr_sel = WS_VAL_NODE;
                w.cond   = C_NOT_ROOT;
                w.target = S_I_UP;
            end
            S_FIN:      w.done = 1'b1;
            S_ERR:      begin w.done = 1'b1; w.err = 1'b1; end
            // extract: read root, descend to the winning leaf
            S_X_ROOT:   begin w.rd_sel = RS_ROOT; w.node_sel = NS_ZERO; end
            S_X_KIDS:   begin w.rd_sel = RS_KIDS; w.res_ld = 1'b1; end
            S_X_PICK:   w.node_sel = NS_WINNER;
            S_X_TEST:   begin w.cond = C_AT_LEAF; w.target = S_X_LAST; end
            S_X_DOWN:   begin w.rd_sel = RS_KIDS; w.cond = C_ALWAYS; w.target = S_X_PICK; end
            // move last leaf into the freed one and empty the last
            S_X_LAST:   begin w.aux_ld = 1'b1; w.node_sel = NS_LAST; end
            S_X_RDL:    w.rd_sel = RS_NODE;
            S_X_MOVE:   w.wr_sel = WS_RDA_AUX;
            S_X_CLR:    begin w.wr_sel = WS_EMPTY_NODE; w.cnt_op = CO_DEC; end
            // replay path above the last leaf
            S_R_UP:     w.node_sel = NS_PARENT;
            S_R_KIDS:   w.rd_sel = RS_KIDS;
            S_R_WR: begin
                w.wr_sel = WS_WIN_NODE;
                w.cond   = C_NOT_ROOT;
                w.target = S_R_UP;
            end
            S_R_AUX:    w.node_sel = NS_AUX;
            // replay path above the freed leaf
            S_S_UP:     w.node_sel = NS_PARENT;
            S_S_KIDS:   w.rd_sel = RS_KIDS;
            S_S_WR: begin
                w.wr_sel = WS_WIN_NODE;
                w.cond   = C_NOT_ROOT;
                w.target = S_S_UP;
            end
            S_S_END:    begin w.cond = C_ALWAYS; w.target = S_FIN; end
            default:    begin w.done = 1'b1; w.err = 1'b1; end
        endcase
        return w;
    endfunction

endpackage

### rtl/mtt_if.sv
// ----------------------------------------------------------------------------
// mtt_if
// valid/ready channels for requests into and results out of the tree
// ----------------------------------------------------------------------------
interface mtt_in_if;
    import mtt_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mtt_out_if;
    import mtt_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/max_tournament_tree.sv
// ----------------------------------------------------------------------------
// max_tournament_tree
// max winner tree over 32 leaves, insert and extract-max requests
// ----------------------------------------------------------------------------
// i_req carries one request: op 0 inserts value_in into the next free leaf,
// op 1 removes and returns the current maximum. o_rsp returns exactly one
// result per request: value_out (maximum on extract, else zero), error
// (insert when full, extract when empty; state is left as it was) and the
// occupancy after the request.
// Requests run one at a time on a program sequencer, one step a cycle
// while not stalled on a held result, against a node memory with one write
// port: a request is accepted only while the sequencer is idle.
// The next request can be accepted in the same cycle as a result is posted.
// Reset empties every node through its valid flop; no clearing pass. A
// stalled result is held in the output register while the next request is
// taken and worked; that request waits at its last step until the held
// result is taken.
// ----------------------------------------------------------------------------
module max_tournament_tree (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mtt_in_if.sink          i_req,
    mtt_out_if.source       o_rsp
);
    import mtt_pkg::*;

    t_ctl      w_ctl;
    t_status   w_status;
    t_ram_req  w_ram_req;
    t_ram_rsp  w_ram_rsp;
    logic      w_in_ready;
    logic      w_out_valid;
    t_out_item w_out_data;

    mtt_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_ctl       (w_ctl)
    );

    mtt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_in_data  (i_req.data),
        .o_out_data (w_out_data),
        .o_status   (w_status),
        .o_ram_req  (w_ram_req),
        .i_ram_rsp  (w_ram_rsp)
    );

    mtt_node_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ram_req),
        .o_rsp   (w_ram_rsp)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;
    assign o_rsp.data  = w_out_data;

endmodule

### rtl/mtt_node_store.sv
// ----------------------------------------------------------------------------
// mtt_node_store
// tree node memory: one write port, two registered read ports, valid flops
// ----------------------------------------------------------------------------
module mtt_node_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtt_pkg::t_ram_req  i_req,
    output mtt_pkg::t_ram_rsp  o_rsp
);
    import mtt_pkg::*;

    logic [DATA_W-1:0]     r_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_valid;
    t_node                 r_rd_a;
    t_node                 r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= i_req.wr_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_a_en) begin
            r_rd_a.valid <= r_valid[i_req.rd_a_addr];
            r_rd_a.value <= r_mem[i_req.rd_a_addr];
        end
        if (i_req.rd_b_en) begin
            r_rd_b.valid <= r_valid[i_req.rd_b_addr];
            r_rd_b.value <= r_mem[i_req.rd_b_addr];
        end
    end

    assign o_rsp.rd_a       = r_rd_a;
    assign o_rsp.rd_b       = r_rd_b;
    assign o_rsp.root_valid = r_valid[0];

endmodule

### rtl/mtt_datapath.sv
// ----------------------------------------------------------------------------
// mtt_datapath
// node index, moved value, count and result registers driven by the program
// ----------------------------------------------------------------------------
`include "max_tournament_tree_macros.svh"

module mtt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtt_pkg::t_ctl      i_ctl,
    input  mtt_pkg::t_in_item  i_in_data,
    output mtt_pkg::t_out_item o_out_data,
    output mtt_pkg::t_status   o_status,
    output mtt_pkg::t_ram_req  o_ram_req,
    input  mtt_pkg::t_ram_rsp  i_ram_rsp
);
    import mtt_pkg::*;

    // a strictly beats b; an empty node loses to any value
    function automatic logic node_beats(input t_node a, input t_node b);
        return a.valid && (!b.valid || (a.value > b.value));
    endfunction

    t_uword            w_uw;
    logic              w_fire;
    logic              r_op;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_res;
    t_idx              r_node;
    t_idx              r_aux;
    t_cnt              r_cnt;
    t_out_item         r_out;
    t_idx              w_left;
    t_idx              w_right;
    t_idx              w_parent;
    t_idx              w_new_leaf;
    t_idx              w_last;
    logic              w_right_wins;
    t_node             w_val_node;

    assign w_uw   = i_ctl.uw;
    assign w_fire = i_ctl.fire;

    assign w_left       = IDX_W'({r_node, 1'b1});
    assign w_right      = IDX_W'({r_node, 1'b0} + (IDX_W + 1)'(2));
    assign w_parent     = IDX_W'((r_node - IDX_W'(1)) >> 1);
    assign w_new_leaf   = IDX_W'(FIRST_LEAF) + IDX_W'(r_cnt);
    assign w_last       = w_new_leaf - IDX_W'(1);
    assign w_right_wins = node_beats(i_ram_rsp.rd_b, i_ram_rsp.rd_a);
    assign w_val_node   = '{valid: 1'b1, value: r_val};

    always_comb begin
        o_status.op_ext    = (r_op == OP_EXTRACT);
        o_status.err_cond  = (r_op == OP_EXTRACT)
                           ? ((r_cnt == '0) || !i_ram_rsp.root_valid)
                           : (r_cnt == CNT_W'(LEAVES));
        o_status.not_beats = !node_beats(w_val_node, i_ram_rsp.rd_a);
        o_status.not_root  = (r_node != '0);
        o_status.at_leaf   = (r_node >= IDX_W'(FIRST_LEAF));
    end

    always_comb begin
        o_ram_req.rd_a_en   = 1'b0;
        o_ram_req.rd_a_addr = w_left;
        o_ram_req.rd_b_en   = 1'b0;
        o_ram_req.rd_b_addr = w_right;
        o_ram_req.wr_en     = 1'b0;
        o_ram_req.wr_addr   = r_node;
        o_ram_req.wr_data   = w_val_node;
        case (w_uw.rd_sel)
            RS_PARENT: begin
                o_ram_req.rd_a_en   = w_fire;
                o_ram_req.rd_a_addr = w_parent;
            end
            RS_ROOT: begin
                o_ram_req.rd_a_en   = w_fire;
                o_ram_req.rd_a_addr = '0;
            end
            RS_KIDS: begin
                o_ram_req.rd_a_en = w_fire;
                o_ram_req.rd_b_en = w_fire;
            end
            RS_NODE: begin
                o_ram_req.rd_a_en   = w_fire;
                o_ram_req.rd_a_addr = r_node;
            end
            default: ;
        endcase
        case (w_uw.wr_sel)
            WS_VAL_NODE: o_ram_req.wr_en = w_fire;
            WS_RDA_AUX: begin
                o_ram_req.wr_en   = w_fire;
                o_ram_req.wr_addr = r_aux;
                o_ram_req.wr_data = i_ram_rsp.rd_a;
            end
            WS_EMPTY_NODE: begin
                o_ram_req.wr_en   = w_fire;
                o_ram_req.wr_data = '0;
            end
            WS_WIN_NODE: begin
                o_ram_req.wr_en   = w_fire;
                o_ram_req.wr_data = w_right_wins ? i_ram_rsp.rd_b : i_ram_rsp.rd_a;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_fire) begin
            case (w_uw.cnt_op)
                CO_INC:  r_cnt <= r_cnt + CNT_W'(1);
                CO_DEC:  r_cnt <= r_cnt - CNT_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_op  <= i_in_data.op;
            r_val <= i_in_data.value_in[DATA_W-1:0];
        end
        if (w_fire) begin
            case (w_uw.node_sel)
                NS_NEW_LEAF: r_node <= w_new_leaf;
                NS_PARENT:   r_node <= w_parent;
                NS_ZERO:     r_node <= '0;
                NS_WINNER:   r_node <= w_right_wins ? w_right : w_left;
                NS_LAST:     r_node <= w_last;
                NS_AUX:      r_node <= r_aux;
                default:     ;
            endcase
            if (w_uw.aux_ld) begin
                r_aux <= r_node;
            end
            if (w_uw.res_ld) begin
                r_res <= i_ram_rsp.rd_a.value;
            end
            if (w_uw.done) begin
                r_out.value_out <= (w_uw.err || (r_op == OP_INSERT))
                                 ? '0 : VALUE_W'(r_res);
                r_out.error     <= w_uw.err;
                r_out.occupancy <= OCC_W'(r_cnt);
            end
        end
    end

    assign o_out_data = r_out;

    `MTT_ASSERT(a_cnt_range, r_cnt <= CNT_W'(LEAVES), "stored count above leaf count")
    `MTT_ASSERT(a_move_to_leaf, !(w_fire && (w_uw.wr_sel == WS_RDA_AUX)) || (r_aux >= IDX_W'(FIRST_LEAF)), "moved value not written to a leaf")
    `MTT_ASSERT(a_descend_bounded, !(w_fire && (w_uw.rd_sel == RS_KIDS)) || (r_node < IDX_W'(FIRST_LEAF)), "children read below a leaf")

endmodule

### rtl/mtt_sequencer.sv
// ----------------------------------------------------------------------------
// mtt_sequencer
// step counter over the control program, jumps and channel handshakes
// ----------------------------------------------------------------------------
`include "max_tournament_tree_macros.svh"

module mtt_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mtt_pkg::t_status i_status,
    output mtt_pkg::t_ctl    o_ctl
);
    import mtt_pkg::*;

    logic   r_busy;
    logic   n_busy;
    t_step  r_step;
    t_step  n_step;
    logic   r_out_valid;
    logic   n_out_valid;
    t_uword w_uw;
    logic   w_accept;
    logic   w_stall;
    logic   w_fire;
    logic   w_jump;

    assign w_uw     = ucode(r_step);
    assign w_accept = i_in_valid && !r_busy;
    // a finishing step waits while the previous result is still held
    assign w_stall  = w_uw.done && r_out_valid && !i_out_ready;
    assign w_fire   = r_busy && !w_stall;

    always_comb begin
        case (w_uw.cond)
            C_ALWAYS:    w_jump = 1'b1;
            C_ERROR:     w_jump = i_status.err_cond;
            C_OP_EXT:    w_jump = i_status.op_ext;
            C_NOT_BEATS: w_jump = i_status.not_beats;
            C_NOT_ROOT:  w_jump = i_status.not_root;
            C_AT_LEAF:   w_jump = i_status.at_leaf;
            default:     w_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = S_DISP_ERR;
        end else if (w_fire) begin
            if (w_uw.done) begin
                n_busy      = 1'b0;
                n_out_valid = 1'b1;
            end else if (w_jump) begin
                n_step = w_uw.target;
            end else begin
                n_step = t_step'(r_step + STEP_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= S_DISP_ERR;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_ctl.uw     = w_uw;
    assign o_ctl.accept = w_accept;
    assign o_ctl.fire   = w_fire;

    `MTT_ASSERT_NEXT(a_accept_starts, w_accept, r_busy && (r_step == S_DISP_ERR), "request did not start the program")
    `MTT_ASSERT_NEXT(a_done_posts, w_fire && w_uw.done, r_out_valid && !r_busy, "finished request not posted")
    `MTT_ASSERT(a_step_range, !r_busy || (r_step <= S_S_END), "step counter outside program")

endmodule
